FILE: sv/jrsa_pkg.sv
// Shared types and constants for the journal ring slot allocator.
// No dependencies; imported by jrsa_table and journal_ring_slot_allocator.
package jrsa_pkg;

  // Ring geometry
  localparam int MAX_BLOCKS        = 16384;
  localparam int BLK_W             = $clog2(MAX_BLOCKS);
  localparam int RING_W            = BLK_W + 1;
  localparam int RECORDS_PER_BLOCK = 64;
  localparam int FILL_W            = $clog2(RECORDS_PER_BLOCK + 1);
  localparam int SLOT_W            = 6;
  localparam int MAX_WAITING       = 1024;
  localparam int WAIT_W            = $clog2(MAX_WAITING + 1);
  localparam int CNT_W             = 11;
  localparam int SEQ_W             = 64;

  // Register port
  localparam int CFG_W   = 15;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic [PADDR_W-3:0] REG_BLOCKS_IN_USE = 1'b0;

  // Input word kinds
  typedef enum logic [2:0] {
    EV_APPEND       = 3'd0,
    EV_WRITE_DONE   = 3'd1,
    EV_TRUNCATE     = 3'd2,
    EV_REPLAY_BEGIN = 3'd3,
    EV_REPLAY_BLOCK = 3'd4,
    EV_REPLAY_END   = 3'd5
  } ev_kind_t;

  // Result word kinds
  typedef enum logic [2:0] {
    RK_ASSIGNED = 3'd0,
    RK_ISSUE    = 3'd1,
    RK_DONE     = 3'd2,
    RK_REJECT   = 3'd3,
    RK_REPLAY   = 3'd4
  } res_kind_t;

  // Result status codes
  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_IO_ERR     = 3'd1,
    ST_NO_SPACE   = 3'd2,
    ST_BUSY       = 3'd3,
    ST_QUEUE_FULL = 3'd4
  } status_t;

  // Access request to the per-block top sequence table
  typedef struct packed {
    logic             rd_en;
    logic [BLK_W-1:0] rd_addr;
    logic             wr_en;
    logic [BLK_W-1:0] wr_addr;
    logic [SEQ_W-1:0] wr_data;
  } tbl_req_t;

endpackage

FILE: sv/journal_ring_slot_allocator.sv
// Journal ring slot allocator: top level with sequencer, register port and output register.
// Depends on jrsa_pkg and jrsa_table.
// The input word is latched, then the first result word is loaded into the output register
// once that register is free. A word is taken only in the idle state; an append or write
// completion that starts a fill passes fill start, wrap check (full block) and fill issue.
// Reset: synchronous; a clearing pass zeroes the block table, item_ready
// stays low meanwhile (register writes are taken throughout).
module journal_ring_slot_allocator import jrsa_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  // input words
  input  logic                item_valid,
  output logic                item_ready,
  input  logic [2:0]          kind,
  input  logic                ok,
  input  logic [SEQ_W-1:0]    lsn_value,
  input  logic [BLK_W-1:0]    block_index,
  input  logic [SEQ_W-1:0]    block_top_lsn,
  input  logic [FILL_W-1:0]   valid_count,
  // result words
  output logic                result_valid,
  input  logic                result_ready,
  output logic [2:0]          result_kind,
  output logic [SEQ_W-1:0]    lsn,
  output logic [BLK_W-1:0]    target_block,
  output logic [SLOT_W-1:0]   first_slot,
  output logic [CNT_W-1:0]    slot_count,
  output logic [2:0]          status,
  output logic                load_tail,
  output logic                last,
  // register port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [PDATA_W-1:0]  pwdata,
  output logic [PDATA_W-1:0]  prdata,
  output logic                pready
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_KSTART,
    S_KCHECK,
    S_KISSUE
  } state_t;

  state_t state;

  // Journal state
  logic [SEQ_W-1:0]  next_seq;
  logic [BLK_W-1:0]  current_block;
  logic [FILL_W-1:0] current_fill;
  logic [SEQ_W-1:0]  truncation_point;
  logic              write_pending;
  logic [FILL_W-1:0] pending_batch;
  logic [WAIT_W-1:0] waiting_count;
  logic              replay_busy;
  logic [BLK_W-1:0]  tail_blk;
  logic [SEQ_W-1:0]  tail_seq;
  logic [FILL_W-1:0] tail_fill;
  logic [SEQ_W-1:0]  replay_max_seq;
  logic [CFG_W-1:0]  blocks_in_use;

  // Latched input word and fill scratch
  logic [2:0]        op_kind;
  logic              op_ok;
  logic [SEQ_W-1:0]  op_lsn;
  logic [BLK_W-1:0]  op_bi;
  logic [SEQ_W-1:0]  op_top;
  logic [FILL_W-1:0] op_vc;
  logic [SEQ_W-1:0]  first;
  logic [BLK_W-1:0]  nb;

  tbl_req_t          tbl_req;
  logic [SEQ_W-1:0]  tbl_rd_data;
  logic              clearing;

  jrsa_table u_table (
    .clk      (clk),
    .rst      (rst),
    .req      (tbl_req),
    .rd_data  (tbl_rd_data),
    .clearing (clearing)
  );

  // Derived values
  logic [CFG_W-1:0]  ring_blocks;
  logic [RING_W-1:0] nb_inc;
  logic [BLK_W-1:0]  nb_calc;
  logic              bi_in_ring;
  logic              block_full;
  logic              kick_go;
  logic              kick_after_done;
  logic [FILL_W-1:0] space;
  logic [FILL_W-1:0] batch;
  logic [FILL_W-1:0] vc_sat;
  logic              result_free;
  logic              result_load;
  logic              tail_load;
  logic [WAIT_W:0]   outstanding;

  always_comb begin
    ring_blocks = blocks_in_use;
    if (blocks_in_use < CFG_W'(2)) begin
      ring_blocks = CFG_W'(2);
    end else if (blocks_in_use > CFG_W'(MAX_BLOCKS)) begin
      ring_blocks = CFG_W'(MAX_BLOCKS);
    end
  end

  assign nb_inc          = {1'b0, current_block} + 1'b1;
  assign nb_calc         = (CFG_W'(nb_inc) >= ring_blocks) ? '0 : nb_inc[BLK_W-1:0];
  assign bi_in_ring      = CFG_W'(op_bi) < ring_blocks;
  assign block_full      = current_fill >= FILL_W'(RECORDS_PER_BLOCK);
  assign kick_go         = !write_pending && !replay_busy && (waiting_count != '0);
  assign kick_after_done = !replay_busy && (waiting_count != '0);
  assign space           = FILL_W'(RECORDS_PER_BLOCK) - current_fill;
  assign batch           = (waiting_count < WAIT_W'(space)) ?
                           waiting_count[FILL_W-1:0] : space;
  assign vc_sat          = (op_vc > FILL_W'(RECORDS_PER_BLOCK)) ?
                           FILL_W'(RECORDS_PER_BLOCK) : op_vc;
  assign result_free     = !result_valid || result_ready;
  assign tail_load       = (tail_fill != '0) && (tail_fill < FILL_W'(RECORDS_PER_BLOCK));
  assign outstanding     = (WAIT_W + 1)'(waiting_count) + (WAIT_W + 1)'(pending_batch);
  assign item_ready      = (state == S_IDLE) && !clearing;

  // A result word is loaded into the output register in this cycle
  always_comb begin
    result_load = 1'b0;
    case (state)
      S_EXEC: begin
        case (op_kind)
          EV_APPEND:     result_load = result_free;
          EV_WRITE_DONE: result_load = result_free && write_pending;
          EV_REPLAY_END: result_load = result_free && replay_busy;
          default:       result_load = 1'b0;
        endcase
      end
      S_KCHECK: result_load = result_free && (tbl_rd_data > truncation_point);
      S_KISSUE: result_load = result_free;
      default:  result_load = 1'b0;
    endcase
  end

  // Table accesses: replay scan writes, wrap check reads, fill issue writes
  always_comb begin
    tbl_req = '0;
    case (state)
      S_EXEC: begin
        if (op_kind == EV_REPLAY_BLOCK && replay_busy && op_ok && bi_in_ring) begin
          tbl_req.wr_en   = 1'b1;
          tbl_req.wr_addr = op_bi;
          tbl_req.wr_data = op_top;
        end
      end
      S_KSTART: begin
        if (kick_go && block_full) begin
          tbl_req.rd_en   = 1'b1;
          tbl_req.rd_addr = nb_calc;
        end
      end
      S_KISSUE: begin
        if (result_free) begin
          tbl_req.wr_en   = 1'b1;
          tbl_req.wr_addr = current_block;
          tbl_req.wr_data = first + SEQ_W'(batch - 1'b1);
        end
      end
      default: begin
      end
    endcase
  end

  // Register port
  assign pready = 1'b1;
  assign prdata = (paddr[PADDR_W-1:2] == REG_BLOCKS_IN_USE) ?
                  PDATA_W'(blocks_in_use) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      blocks_in_use <= CFG_W'(MAX_BLOCKS);
    end else if (psel && penable && pwrite && pready &&
                 paddr[PADDR_W-1:2] == REG_BLOCKS_IN_USE) begin
      blocks_in_use <= pwdata[CFG_W-1:0];
    end
  end

  // Sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      result_valid     <= 1'b0;
      next_seq         <= SEQ_W'(1);
      current_block    <= '0;
      current_fill     <= '0;
      truncation_point <= '0;
      write_pending    <= 1'b0;
      pending_batch    <= '0;
      waiting_count    <= '0;
      replay_busy      <= 1'b0;
      tail_blk         <= '0;
      tail_seq         <= '0;
      tail_fill        <= '0;
      replay_max_seq   <= '0;
    end else begin
      if (result_ready && !result_load) begin
        result_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (item_valid && item_ready) begin
            op_kind <= kind;
            op_ok   <= ok;
            op_lsn  <= lsn_value;
            op_bi   <= block_index;
            op_top  <= block_top_lsn;
            op_vc   <= valid_count;
            state   <= S_EXEC;
          end
        end

        S_EXEC: begin
          case (op_kind)
            EV_APPEND: begin
              if (result_free) begin
                result_valid <= 1'b1;
                target_block <= current_block;
                first_slot   <= '0;
                slot_count   <= CNT_W'(1);
                load_tail    <= 1'b0;
                if (replay_busy || waiting_count >= WAIT_W'(MAX_WAITING)) begin
                  result_kind <= RK_REJECT;
                  lsn         <= '0;
                  status      <= replay_busy ? ST_BUSY : ST_QUEUE_FULL;
                  last        <= 1'b1;
                  state       <= S_IDLE;
                end else begin
                  // a fill follows unless a write is still outstanding
                  result_kind   <= RK_ASSIGNED;
                  lsn           <= next_seq;
                  status        <= ST_OK;
                  last          <= write_pending;
                  next_seq      <= next_seq + 1'b1;
                  waiting_count <= waiting_count + 1'b1;
                  state         <= write_pending ? S_IDLE : S_KSTART;
                end
              end
            end
            EV_WRITE_DONE: begin
              if (!write_pending) begin
                state <= S_IDLE;
              end else if (result_free) begin
                result_valid  <= 1'b1;
                result_kind   <= RK_DONE;
                lsn           <= next_seq - SEQ_W'(outstanding);
                target_block  <= current_block;
                first_slot    <= '0;
                slot_count    <= CNT_W'(pending_batch);
                status        <= op_ok ? ST_OK : ST_IO_ERR;
                load_tail     <= 1'b0;
                last          <= !kick_after_done;
                write_pending <= 1'b0;
                pending_batch <= '0;
                state         <= kick_after_done ? S_KSTART : S_IDLE;
              end
            end
            EV_TRUNCATE: begin
              truncation_point <= op_lsn;
              state            <= S_IDLE;
            end
            EV_REPLAY_BEGIN: begin
              replay_busy    <= 1'b1;
              replay_max_seq <= op_lsn;
              tail_blk       <= '0;
              tail_seq       <= '0;
              tail_fill      <= '0;
              state          <= S_IDLE;
            end
            EV_REPLAY_BLOCK: begin
              // table entry is written by the request logic in this cycle
              if (replay_busy && op_ok && bi_in_ring) begin
                if (op_top > tail_seq) begin
                  tail_seq  <= op_top;
                  tail_blk  <= op_bi;
                  tail_fill <= vc_sat;
                end
                if (op_top > replay_max_seq) begin
                  replay_max_seq <= op_top;
                end
              end
              state <= S_IDLE;
            end
            EV_REPLAY_END: begin
              if (!replay_busy) begin
                state <= S_IDLE;
              end else if (result_free) begin
                result_valid  <= 1'b1;
                result_kind   <= RK_REPLAY;
                lsn           <= replay_max_seq + 1'b1;
                target_block  <= tail_blk;
                first_slot    <= '0;
                slot_count    <= CNT_W'(tail_fill);
                status        <= op_ok ? ST_OK : ST_IO_ERR;
                load_tail     <= tail_load;
                last          <= 1'b1;
                current_block <= tail_blk;
                current_fill  <= tail_fill;
                next_seq      <= replay_max_seq + 1'b1;
                replay_busy   <= 1'b0;
                state         <= S_IDLE;
              end
            end
            default: begin
              state <= S_IDLE;
            end
          endcase
        end

        // Fill start: first waiting number, and a table read when the block is full
        S_KSTART: begin
          first <= next_seq - SEQ_W'(waiting_count);
          nb    <= nb_calc;
          if (!kick_go) begin
            state <= S_IDLE;
          end else if (block_full) begin
            state <= S_KCHECK;
          end else begin
            state <= S_KISSUE;
          end
        end

        // Wrap check against the truncation point
        S_KCHECK: begin
          if (tbl_rd_data > truncation_point) begin
            if (result_free) begin
              result_valid  <= 1'b1;
              result_kind   <= RK_REJECT;
              lsn           <= first;
              target_block  <= nb;
              first_slot    <= '0;
              slot_count    <= CNT_W'(waiting_count);
              status        <= ST_NO_SPACE;
              load_tail     <= 1'b0;
              last          <= 1'b1;
              waiting_count <= '0;
              state         <= S_IDLE;
            end
          end else begin
            current_block <= nb;
            current_fill  <= '0;
            state         <= S_KISSUE;
          end
        end

        // Issue the write for as many waiting appends as the block holds
        S_KISSUE: begin
          if (result_free) begin
            result_valid  <= 1'b1;
            result_kind   <= RK_ISSUE;
            lsn           <= first;
            target_block  <= current_block;
            first_slot    <= current_fill[SLOT_W-1:0];
            slot_count    <= CNT_W'(batch);
            status        <= ST_OK;
            load_tail     <= 1'b0;
            last          <= 1'b1;
            current_fill  <= current_fill + batch;
            waiting_count <= waiting_count - WAIT_W'(batch);
            pending_batch <= batch;
            write_pending <= 1'b1;
            state         <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // No word enters while the table is being cleared
  assert property (@(posedge clk) disable iff (rst) clearing |-> !item_ready)
    else $error("input word taken during table clearing");

  // Sequencer never touches the table during the clearing sweep
  assert property (@(posedge clk) disable iff (rst)
    clearing |-> (!tbl_req.wr_en && !tbl_req.rd_en))
    else $error("table access during clearing");

  // Wait count and fill stay within their bounds
  assert property (@(posedge clk) disable iff (rst)
    (waiting_count <= WAIT_W'(MAX_WAITING)) &&
    (current_fill <= FILL_W'(RECORDS_PER_BLOCK)))
    else $error("wait count or block fill out of range");

  // An issued write leaves a write outstanding
  assert property (@(posedge clk) disable iff (rst)
    (state == S_KISSUE && result_free) |=> write_pending)
    else $error("write issued without pending flag");

  // A fill only starts with nothing outstanding and no replay running
  assert property (@(posedge clk) disable iff (rst)
    (state == S_KISSUE) |-> (!write_pending && !replay_busy && waiting_count != '0))
    else $error("fill started while blocked");

endmodule

FILE: sv/jrsa_table.sv
// Per-block highest sequence number table: one synchronous RAM with a registered read.
// Sweeps every entry to zero after reset. Depends on jrsa_pkg.
module jrsa_table import jrsa_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  tbl_req_t         req,
  output logic [SEQ_W-1:0] rd_data,
  output logic             clearing
);

  logic [SEQ_W-1:0] mem [MAX_BLOCKS];
  logic [RING_W-1:0] clr_ptr;

  // Clearing sweep: one entry per cycle until the whole table is zero
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_ptr  <= '0;
      clearing <= 1'b1;
    end else if (clearing) begin
      clr_ptr <= clr_ptr + 1'b1;
      if (clr_ptr == RING_W'(MAX_BLOCKS - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  // Write port, owned by the sweep while clearing
  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_ptr[BLK_W-1:0]] <= '0;
    end else if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  // Registered read; data holds until the next read
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end

endmodule

FILE: test/tb_journal_ring_slot_allocator.sv
`timescale 1ns / 1ps
// Testbench for journal_ring_slot_allocator: directed and random event words, with results
// checked against an in-bench model of the ring sequencer. Depends on jrsa_pkg and the RTL.
module tb_journal_ring_slot_allocator;
  import jrsa_pkg::*;

  typedef logic [SEQ_W-1:0] seq_t;

  // Event word as driven on the input channel
  typedef struct {
    logic [2:0]        kind;
    logic              ok;
    seq_t              lsn_value;
    logic [BLK_W-1:0]  block_index;
    seq_t              block_top_lsn;
    logic [FILL_W-1:0] valid_count;
  } journal_word_t;

  // Result word as expected on the output channel
  typedef struct {
    res_kind_t         kind;
    seq_t              lsn;
    logic [BLK_W-1:0]  blk;
    logic [SLOT_W-1:0] slot;
    logic [CNT_W-1:0]  cnt;
    status_t           st;
    logic              load;
    logic              last;
  } journal_result_t;

  // Kinds with no meaning; the block must ignore them
  localparam logic [2:0] EV_UNDEF_LO = 3'd6;
  localparam logic [2:0] EV_UNDEF_HI = 3'd7;
  localparam int STALL_LIMIT = 60000;
  localparam int QUEUE_FULL_BURST = MAX_WAITING + 7;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                item_valid = 1'b0;
  logic                item_ready;
  logic [2:0]          kind = '0;
  logic                ok = 1'b0;
  seq_t                lsn_value = '0;
  logic [BLK_W-1:0]    block_index = '0;
  seq_t                block_top_lsn = '0;
  logic [FILL_W-1:0]   valid_count = '0;
  logic                result_valid;
  logic                result_ready = 1'b0;
  logic [2:0]          result_kind;
  seq_t                lsn;
  logic [BLK_W-1:0]    target_block;
  logic [SLOT_W-1:0]   first_slot;
  logic [CNT_W-1:0]    slot_count;
  logic [2:0]          status;
  logic                load_tail;
  logic                last;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [PADDR_W-1:0]  paddr = '0;
  logic [PDATA_W-1:0]  pwdata = '0;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  journal_ring_slot_allocator u_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .kind         (kind),
    .ok           (ok),
    .lsn_value    (lsn_value),
    .block_index  (block_index),
    .block_top_lsn(block_top_lsn),
    .valid_count  (valid_count),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_kind  (result_kind),
    .lsn          (lsn),
    .target_block (target_block),
    .first_slot   (first_slot),
    .slot_count   (slot_count),
    .status       (status),
    .load_tail    (load_tail),
    .last         (last),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Stimulus and scoreboard stores
  journal_word_t   event_words[$];
  journal_result_t pending_results[$];
  journal_result_t step_words[$];
  int  mismatches = 0;
  int  quiet_cycles = 0;
  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  bit  in_fire = 1'b0;
  bit  out_fire = 1'b0;

  // Model state of the sequencer
  int   ring_size = MAX_BLOCKS;
  seq_t seq_next = 64'd1;
  logic [BLK_W-1:0] cursor_blk = '0;
  int   cur_fill = 0;
  seq_t blk_top[MAX_BLOCKS];
  seq_t trunc_point = '0;
  bit   wr_pending = 1'b0;
  int   pend_batch = 0;
  int   waiting = 0;
  bit   replay_busy = 1'b0;
  logic [BLK_W-1:0] tail_blk = '0;
  seq_t tail_seq = '0;
  int   tail_fill = 0;
  seq_t replay_max = '0;

  function automatic seq_t rand_seq();
    return {$urandom, $urandom};
  endfunction

  function automatic void post_word(res_kind_t k, seq_t l, logic [BLK_W-1:0] b,
                                    logic [SLOT_W-1:0] s, int c, status_t st, logic ld);
    journal_result_t r;
    r.kind = k;
    r.lsn  = l;
    r.blk  = b;
    r.slot = s;
    r.cnt  = CNT_W'(c);
    r.st   = st;
    r.load = ld;
    r.last = 1'b0;
    step_words.push_back(r);
  endfunction

  // Fill the current block from the waiting appends, moving on a block when full
  function automatic void start_fill();
    logic [BLK_W-1:0] nb;
    int   space;
    int   batch;
    seq_t first;
    if (wr_pending || replay_busy || waiting == 0) return;
    if (cur_fill >= RECORDS_PER_BLOCK) begin
      nb = (int'(cursor_blk) + 1 >= ring_size) ? '0 : cursor_blk + 1'b1;
      if (blk_top[nb] > trunc_point) begin
        post_word(RK_REJECT, seq_next - seq_t'(waiting), nb, '0, waiting, ST_NO_SPACE, 1'b0);
        waiting = 0;
        return;
      end
      cursor_blk = nb;
      cur_fill = 0;
    end
    space = RECORDS_PER_BLOCK - cur_fill;
    batch = (waiting < space) ? waiting : space;
    first = seq_next - seq_t'(waiting);
    blk_top[cursor_blk] = first + seq_t'(batch) - 64'd1;
    post_word(RK_ISSUE, first, cursor_blk, SLOT_W'(cur_fill), batch, ST_OK, 1'b0);
    cur_fill += batch;
    waiting -= batch;
    pend_batch = batch;
    wr_pending = 1'b1;
  endfunction

  // Work out the result words of one accepted event word
  function automatic void ring_step(journal_word_t w);
    int vc;
    step_words.delete();
    case (w.kind)
      EV_APPEND: begin
        if (replay_busy) begin
          post_word(RK_REJECT, '0, cursor_blk, '0, 1, ST_BUSY, 1'b0);
        end else if (waiting >= MAX_WAITING) begin
          post_word(RK_REJECT, '0, cursor_blk, '0, 1, ST_QUEUE_FULL, 1'b0);
        end else begin
          post_word(RK_ASSIGNED, seq_next, cursor_blk, '0, 1, ST_OK, 1'b0);
          seq_next += 64'd1;
          waiting++;
          start_fill();
        end
      end
      EV_WRITE_DONE: begin
        if (wr_pending) begin
          post_word(RK_DONE, seq_next - seq_t'(waiting) - seq_t'(pend_batch), cursor_blk, '0,
                    pend_batch, w.ok ? ST_OK : ST_IO_ERR, 1'b0);
          wr_pending = 1'b0;
          pend_batch = 0;
          start_fill();
        end
      end
      EV_TRUNCATE: trunc_point = w.lsn_value;
      EV_REPLAY_BEGIN: begin
        replay_busy = 1'b1;
        replay_max = w.lsn_value;
        tail_blk = '0;
        tail_seq = '0;
        tail_fill = 0;
      end
      EV_REPLAY_BLOCK: begin
        if (replay_busy && w.ok && int'(w.block_index) < ring_size) begin
          vc = (w.valid_count > RECORDS_PER_BLOCK) ? RECORDS_PER_BLOCK : int'(w.valid_count);
          blk_top[w.block_index] = w.block_top_lsn;
          if (w.block_top_lsn > tail_seq) begin
            tail_seq = w.block_top_lsn;
            tail_blk = w.block_index;
            tail_fill = vc;
          end
          if (w.block_top_lsn > replay_max) replay_max = w.block_top_lsn;
        end
      end
      EV_REPLAY_END: begin
        if (replay_busy) begin
          cursor_blk = tail_blk;
          cur_fill = tail_fill;
          seq_next = replay_max + 64'd1;
          replay_busy = 1'b0;
          post_word(RK_REPLAY, seq_next, tail_blk, '0, tail_fill, w.ok ? ST_OK : ST_IO_ERR,
                    tail_fill > 0 && tail_fill < RECORDS_PER_BLOCK);
        end
      end
      default: ;
    endcase
    if (step_words.size() > 0) step_words[step_words.size() - 1].last = 1'b1;
    foreach (step_words[i]) pending_results.push_back(step_words[i]);
  endfunction

  function automatic void report_mismatch(string what, seq_t want, seq_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t mismatch on %s: expected %0h, got %0h", $realtime, what, want, got);
  endfunction

  // Sample both channels at the rising edge; predict, check, and watch for a hang
  always @(posedge clk) begin : word_monitor
    journal_word_t   w;
    journal_result_t r;
    in_fire = !rst && item_valid && item_ready;
    out_fire = !rst && result_valid && result_ready;
    if (in_fire) begin
      w.kind = kind;
      w.ok = ok;
      w.lsn_value = lsn_value;
      w.block_index = block_index;
      w.block_top_lsn = block_top_lsn;
      w.valid_count = valid_count;
      ring_step(w);
    end
    if (out_fire) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result word kind", '0, result_kind);
      end else begin
        r = pending_results.pop_front();
        if (result_kind !== r.kind) report_mismatch("result_kind", r.kind, result_kind);
        if (lsn !== r.lsn) report_mismatch("lsn", r.lsn, lsn);
        if (target_block !== r.blk) report_mismatch("target_block", r.blk, target_block);
        if (first_slot !== r.slot) report_mismatch("first_slot", r.slot, first_slot);
        if (slot_count !== r.cnt) report_mismatch("slot_count", r.cnt, slot_count);
        if (status !== r.st) report_mismatch("status", r.st, status);
        if (load_tail !== r.load) report_mismatch("load_tail", r.load, load_tail);
        if (last !== r.last) report_mismatch("last", r.last, last);
      end
    end
    if (in_fire || out_fire) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Drive the input word and the result ready at the falling edge
  always @(negedge clk) begin : word_driver
    journal_word_t w;
    bit give;
    if (!item_valid || in_fire) begin
      give = event_words.size() > 0 && ($urandom_range(99) >= send_idle_pct);
      if (give) begin
        w = event_words.pop_front();
        kind <= w.kind;
        ok <= w.ok;
        lsn_value <= w.lsn_value;
        block_index <= w.block_index;
        block_top_lsn <= w.block_top_lsn;
        valid_count <= w.valid_count;
      end
      item_valid <= give;
    end
    result_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Keep the pending store short so stimulus choices see a recent model state
  task automatic queue_word(logic [2:0] k, logic o, seq_t lv, logic [BLK_W-1:0] bi,
                            seq_t top, logic [FILL_W-1:0] vc);
    journal_word_t w;
    while (event_words.size() >= 8) @(negedge clk);
    w.kind = k;
    w.ok = o;
    w.lsn_value = lv;
    w.block_index = bi;
    w.block_top_lsn = top;
    w.valid_count = vc;
    event_words.push_back(w);
  endtask

  // Word of the given kind with every unused field random
  task automatic queue_rand(logic [2:0] k, logic o);
    queue_word(k, o, rand_seq(), BLK_W'($urandom), rand_seq(), FILL_W'($urandom));
  endtask

  // Register write then read-back, with the block idle
  task automatic write_ring_size(logic [CFG_W-1:0] v);
    logic [PDATA_W-1:0] data;
    data = $urandom;
    data[CFG_W-1:0] = v;
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= {REG_BLOCKS_IN_USE, 2'b00};
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    ring_size = (v < 2) ? 2 : (v > MAX_BLOCKS) ? MAX_BLOCKS : int'(v);
    @(negedge clk);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata[CFG_W-1:0] !== v) report_mismatch("blocks_in_use read-back", v, prdata[CFG_W-1:0]);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // All words taken and all results back, then allow for a word with no result
  task automatic drain();
    wait (event_words.size() == 0 && !item_valid);
    wait (pending_results.size() == 0);
    repeat (20) @(posedge clk);
  endtask

  // Replay scan: begin, a few blocks with occasional stray words, usually an end
  task automatic gen_replay();
    seq_t base;
    seq_t top;
    logic [BLK_W-1:0] idx;
    logic [FILL_W-1:0] vc;
    int n;
    case ($urandom_range(3))
      0: base = seq_next - seq_t'($urandom_range(0, 100));
      1: base = rand_seq();
      2: base = '0;
      default: base = '1 - seq_t'($urandom_range(0, 50));
    endcase
    queue_word(EV_REPLAY_BEGIN, $urandom, base, BLK_W'($urandom), rand_seq(), FILL_W'($urandom));
    n = $urandom_range(0, 6);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) == 0) begin
        case ($urandom_range(2))
          0: queue_rand(EV_APPEND, $urandom);
          1: queue_rand(EV_WRITE_DONE, $urandom);
          default: queue_word(EV_REPLAY_BEGIN, $urandom, base, BLK_W'($urandom), rand_seq(),
                              FILL_W'($urandom));
        endcase
      end
      idx = ($urandom_range(9) == 0) ? BLK_W'($urandom) : BLK_W'($urandom_range(0, ring_size - 1));
      top = ($urandom_range(7) == 0) ? rand_seq() : base + seq_t'($urandom_range(0, 400));
      case ($urandom_range(4))
        0: vc = FILL_W'(RECORDS_PER_BLOCK);
        1: vc = FILL_W'($urandom);
        default: vc = FILL_W'($urandom_range(0, RECORDS_PER_BLOCK - 1));
      endcase
      queue_word(EV_REPLAY_BLOCK, $urandom_range(9) != 0, rand_seq(), idx, top, vc);
    end
    if ($urandom_range(9) != 0) queue_rand(EV_REPLAY_END, $urandom_range(4) != 0);
  endtask

  // Random part: mostly append bursts with completions, plus truncation, replay and noise
  task automatic gen_random(int n_words);
    int made;
    int r;
    int n;
    seq_t tp;
    made = 0;
    while (made < n_words) begin
      r = $urandom_range(99);
      if (r < 55) begin
        n = $urandom_range(1, 80);
        for (int i = 0; i < n; i++) begin
          queue_rand(EV_APPEND, $urandom);
          if ($urandom_range(99) < 35) queue_rand(EV_WRITE_DONE, $urandom_range(99) < 85);
        end
        made += n;
      end else if (r < 65) begin
        n = $urandom_range(1, 4);
        for (int i = 0; i < n; i++) queue_rand(EV_WRITE_DONE, $urandom_range(99) < 85);
        made += n;
      end else if (r < 75) begin
        case ($urandom_range(3))
          0: tp = '0;
          1: tp = '1;
          2: tp = seq_next - seq_t'($urandom_range(0, 300));
          default: tp = rand_seq();
        endcase
        queue_word(EV_TRUNCATE, $urandom, tp, BLK_W'($urandom), rand_seq(), FILL_W'($urandom));
        made++;
      end else if (r < 90) begin
        gen_replay();
        made += 4;
      end else begin
        n = $urandom_range(1, 3);
        for (int i = 0; i < n; i++)
          queue_word(3'($urandom), $urandom, rand_seq(), BLK_W'($urandom), rand_seq(),
                     FILL_W'($urandom));
      end
    end
  endtask

  // Hold appends while a write is out until the wait count is full, then complete
  task automatic gen_queue_full();
    queue_word(EV_TRUNCATE, 1'b0, '1, '0, '0, '0);
    queue_rand(EV_REPLAY_END, 1'b1);
    queue_rand(EV_WRITE_DONE, 1'b1);
    for (int i = 0; i < QUEUE_FULL_BURST; i++) queue_rand(EV_APPEND, $urandom);
    for (int i = 0; i < 20; i++) queue_rand(EV_WRITE_DONE, $urandom_range(9) != 0);
  endtask

  initial begin : stimulus
    logic [CFG_W-1:0] ring_cfg[8];
    foreach (blk_top[i]) blk_top[i] = '0;
    ring_cfg = '{15'd2, 15'd3, 15'd16384, 15'd32767, 15'd1, 15'd5, 15'd16383, 15'd9};
    ring_cfg[5] = CFG_W'($urandom_range(4, 9));
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part: ring clamped up to two blocks, no idling
    write_ring_size('0);
    queue_word(EV_APPEND, 1'b0, '0, '0, '0, '0);
    queue_word(EV_APPEND, 1'b0, '0, '0, '0, '0);
    queue_word(EV_APPEND, 1'b0, '0, '0, '0, '0);
    queue_word(EV_WRITE_DONE, 1'b1, '0, '0, '0, '0);
    queue_word(EV_WRITE_DONE, 1'b0, '0, '0, '0, '0);
    // completion with nothing outstanding, and the two undefined kinds
    queue_word(EV_WRITE_DONE, 1'b1, '1, '1, '1, '1);
    queue_word(EV_UNDEF_LO, 1'b1, '1, '1, '1, '1);
    queue_word(EV_UNDEF_HI, 1'b0, '0, '0, '0, '0);
    queue_word(EV_TRUNCATE, 1'b0, '1, '0, '0, '0);
    // replay: busy append, saturated count, failed block, out-of-ring block, restart
    queue_word(EV_REPLAY_BEGIN, 1'b0, '0, '0, '0, '0);
    queue_word(EV_APPEND, 1'b0, '0, '0, '0, '0);
    queue_word(EV_REPLAY_BLOCK, 1'b1, '0, 14'd1, 64'd100, '1);
    queue_word(EV_REPLAY_BLOCK, 1'b0, '0, 14'd0, 64'd50, '0);
    queue_word(EV_REPLAY_BLOCK, 1'b1, '0, '1, 64'd500, 7'd10);
    queue_word(EV_REPLAY_BEGIN, 1'b1, 64'd200, '0, '0, '0);
    queue_word(EV_REPLAY_BLOCK, 1'b1, '0, 14'd1, 64'hFFFF_FFFF_FFFF_FFFE, 7'd64);
    queue_word(EV_REPLAY_END, 1'b0, '0, '0, '0, '0);
    // sequence numbers roll over; full block wraps to block 0
    queue_word(EV_APPEND, 1'b0, '0, '0, '0, '0);
    queue_word(EV_APPEND, 1'b0, '0, '0, '0, '0);
    queue_word(EV_WRITE_DONE, 1'b1, '0, '0, '0, '0);
    // refused wrap: next block's top is beyond the truncation point
    queue_word(EV_TRUNCATE, 1'b0, '0, '0, '0, '0);
    queue_word(EV_REPLAY_BEGIN, 1'b1, '0, '0, '0, '0);
    queue_word(EV_REPLAY_BLOCK, 1'b1, '0, 14'd0, 64'd9, 7'd64);
    queue_word(EV_REPLAY_BLOCK, 1'b1, '0, 14'd1, 64'd5, 7'd3);
    queue_word(EV_REPLAY_END, 1'b1, '0, '0, '0, '0);
    queue_word(EV_APPEND, 1'b0, '0, '0, '0, '0);
    drain();

    // Random phases across ring sizes and idling patterns
    for (int ph = 0; ph < 8; ph++) begin
      write_ring_size(ring_cfg[ph]);
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 45; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 45; end
        default: begin send_idle_pct = 22; recv_stall_pct = 22; end
      endcase
      gen_random(85);
      if (ph == 3) gen_queue_full();
      drain();
    end

    mismatches += pending_results.size();
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
